// ----- src/m68kea_pkg.sv -----
// ----------------------------------------------------------------------------
// m68kea_pkg
// Shared types and codes for the 68020/030 effective address unit.
// ----------------------------------------------------------------------------
package m68kea_pkg;

  typedef enum logic [1:0] {
    KIND_ADDR = 2'd0,
    KIND_DATA = 2'd1,
    KIND_READ = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  // ea mode field
  localparam logic [2:0] MODE_DREG    = 3'd0;
  localparam logic [2:0] MODE_AREG    = 3'd1;
  localparam logic [2:0] MODE_IND     = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC  = 3'd4;
  localparam logic [2:0] MODE_DISP16  = 3'd5;
  localparam logic [2:0] MODE_INDEX   = 3'd6;
  localparam logic [2:0] MODE_EXT     = 3'd7;

  // sub-modes of mode seven
  localparam logic [2:0] SUB_ABS_W    = 3'd0;
  localparam logic [2:0] SUB_ABS_L    = 3'd1;
  localparam logic [2:0] SUB_PC_D16   = 3'd2;
  localparam logic [2:0] SUB_PC_INDEX = 3'd3;
  localparam logic [2:0] SUB_IMM      = 3'd4;

  // operand size
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  // stack pointer register number
  localparam logic [2:0] REG_SP = 3'd7;

  // full format base displacement size
  localparam logic [1:0] BDSZ_RSVD = 2'd0;
  localparam logic [1:0] BDSZ_NULL = 2'd1;
  localparam logic [1:0] BDSZ_WORD = 2'd2;
  localparam logic [1:0] BDSZ_LONG = 2'd3;

  // full format index/indirect selection
  localparam logic [2:0] IIS_NONE  = 3'd0;
  localparam logic [2:0] IIS_RSVD  = 3'd4;
  localparam logic [1:0] OD_WORD   = 2'd2;
  localparam logic [1:0] OD_LONG   = 2'd3;

  typedef struct packed {
    logic        action;
    logic [2:0]  mode;
    logic [2:0]  reg_req;
    logic [1:0]  size;
    logic [31:0] base_reg_value;
    logic [31:0] pc_value;
    logic [31:0] index_reg_value;
    logic [15:0] ext_word;
    logic [31:0] base_disp;
    logic [31:0] outer_disp;
    logic [31:0] mem_data;
  } ea_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        reg_write;
    logic [31:0] new_reg_value;
  } ea_res_t;

  typedef struct packed {
    logic        pending;
    logic [31:0] addend;
  } ea_state_t;

endpackage

// ----- src/m68k_effective_address_unit.sv -----
// ----------------------------------------------------------------------------
// m68k_effective_address_unit
// 68020/030 effective address calculation for all addressing modes, with
// two-step memory indirect handling and address register update.
//
//   channel   direction   handshake             payload
//   in_       input       in_valid / in_stall   action, mode, reg, size, values
//   out_      output      out_valid / out_stall kind, value, reg_write, new reg
//
// one request per cycle sustained while out_stall is low
// input register, one calculation stage, result register
// pending indirection state updates as a request moves into the result register
// rst_n synchronously clears valid flags and pending indirection
// out_stall holds the result register and stalls the input register behind it
// ----------------------------------------------------------------------------
module m68k_effective_address_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [2:0]  in_mode,
  input  logic [2:0]  in_reg_req,
  input  logic [1:0]  in_size,
  input  logic [31:0] in_base_reg_value,
  input  logic [31:0] in_pc_value,
  input  logic [31:0] in_index_reg_value,
  input  logic [15:0] in_ext_word,
  input  logic [31:0] in_base_disp,
  input  logic [31:0] in_outer_disp,
  input  logic [31:0] in_mem_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_value,
  output logic        out_reg_write,
  output logic [31:0] out_new_reg_value
);
  import m68kea_pkg::*;

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  ea_req_t   s1_req_r;
  ea_req_t   in_req;
  logic      out_valid_r;
  logic      out_valid_nxt;
  ea_res_t   out_res_r;
  ea_res_t   calc_res;
  ea_state_t st_r;
  ea_state_t st_nxt;
  logic      s1_adv;
  logic      in_take;

  assign in_req.action          = in_action;
  assign in_req.mode            = in_mode;
  assign in_req.reg_req         = in_reg_req;
  assign in_req.size            = in_size;
  assign in_req.base_reg_value  = in_base_reg_value;
  assign in_req.pc_value        = in_pc_value;
  assign in_req.index_reg_value = in_index_reg_value;
  assign in_req.ext_word        = in_ext_word;
  assign in_req.base_disp       = in_base_disp;
  assign in_req.outer_disp      = in_outer_disp;
  assign in_req.mem_data        = in_mem_data;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  m68kea_calc u_calc (
    .req    (s1_req_r),
    .st     (st_r),
    .res    (calc_res),
    .st_nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_valid_r && s1_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= in_req;
    end
    if (s1_valid_r && s1_adv) begin
      out_res_r <= calc_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_res_r.kind;
  assign out_value         = out_res_r.value;
  assign out_reg_write     = out_res_r.reg_write;
  assign out_new_reg_value = out_res_r.new_reg_value;

`ifndef SYNTHESIS
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_write_only_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.reg_write) |-> (out_res_r.kind == KIND_ADDR))
    else $error("register update on a non-address result");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == KIND_BAD) |-> (out_res_r.value == 32'd0))
    else $error("invalid result carries a nonzero value");

  a_pending_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.pending) |-> (out_valid_r && out_res_r.kind == KIND_READ))
    else $error("indirection pending without a read request");
`endif

endmodule

// ----- src/m68kea_calc.sv -----
// ----------------------------------------------------------------------------
// m68kea_calc
// Combinational effective address calculation for one request, including
// the memory indirect pending state update.
// ----------------------------------------------------------------------------
module m68kea_calc (
  input  m68kea_pkg::ea_req_t   req,
  input  m68kea_pkg::ea_state_t st,
  output m68kea_pkg::ea_res_t   res,
  output m68kea_pkg::ea_state_t st_nxt
);
  import m68kea_pkg::*;

  logic [31:0] sx_bd;
  logic [31:0] sx_od;
  logic [31:0] sx_idx;
  logic [31:0] idx_sel;
  logic [31:0] scaled;
  logic [31:0] idx_base;
  logic [31:0] brief_ea;
  logic [31:0] base_sel;
  logic [31:0] bdv;
  logic [31:0] odv;
  logic [31:0] xf;
  logic [31:0] base_bd;
  logic [31:0] full_pre;
  logic [2:0]  step;
  logic [31:0] step_ext;
  logic [1:0]  bdsz;
  logic [2:0]  iis;
  logic        idx_sup;
  logic        full_bad;
  kind_t       idx_kind;
  logic [31:0] idx_val;
  logic        idx_pend;
  logic [31:0] idx_addend;

  assign sx_bd   = {{16{req.base_disp[15]}}, req.base_disp[15:0]};
  assign sx_od   = {{16{req.outer_disp[15]}}, req.outer_disp[15:0]};
  assign sx_idx  = {{16{req.index_reg_value[15]}}, req.index_reg_value[15:0]};
  assign idx_sel = req.ext_word[11] ? req.index_reg_value : sx_idx;
  assign scaled  = idx_sel << req.ext_word[10:9];
  assign idx_base = (req.mode == MODE_EXT) ? req.pc_value : req.base_reg_value;
  assign brief_ea = idx_base + {{24{req.ext_word[7]}}, req.ext_word[7:0]} + scaled;

  assign bdsz     = req.ext_word[5:4];
  assign iis      = req.ext_word[2:0];
  assign idx_sup  = req.ext_word[6];
  assign full_bad = req.ext_word[3] || (bdsz == BDSZ_RSVD) || (iis == IIS_RSVD) ||
                    (idx_sup && (iis > 3'd3));
  assign base_sel = req.ext_word[7] ? 32'd0 : idx_base;
  assign xf       = idx_sup ? 32'd0 : scaled;
  assign base_bd  = base_sel + bdv;
  assign full_pre = base_bd + xf;

  always_comb begin
    unique case (bdsz)
      BDSZ_WORD: bdv = sx_bd;
      BDSZ_LONG: bdv = req.base_disp;
      default:   bdv = 32'd0;
    endcase
  end

  always_comb begin
    unique case (iis[1:0])
      OD_WORD: odv = sx_od;
      OD_LONG: odv = req.outer_disp;
      default: odv = 32'd0;
    endcase
  end

  // indexed modes, brief and full format
  always_comb begin
    idx_kind   = KIND_BAD;
    idx_val    = 32'd0;
    idx_pend   = 1'b0;
    idx_addend = 32'd0;
    priority if (!req.ext_word[8]) begin
      idx_kind = KIND_ADDR;
      idx_val  = brief_ea;
    end else if (full_bad) begin
      idx_kind = KIND_BAD;
    end else if (iis == IIS_NONE) begin
      idx_kind = KIND_ADDR;
      idx_val  = full_pre;
    end else if (!iis[2]) begin
      // pre-indexed
      idx_kind   = KIND_READ;
      idx_val    = full_pre;
      idx_pend   = 1'b1;
      idx_addend = odv;
    end else begin
      // post-indexed
      idx_kind   = KIND_READ;
      idx_val    = base_bd;
      idx_pend   = 1'b1;
      idx_addend = xf + odv;
    end
  end

  always_comb begin
    unique case (req.size)
      SIZE_BYTE: step = (req.reg_req == REG_SP) ? 3'd2 : 3'd1;
      SIZE_WORD: step = 3'd2;
      default:   step = 3'd4;
    endcase
  end

  assign step_ext = {29'd0, step};

  always_comb begin
    res.kind          = KIND_BAD;
    res.value         = 32'd0;
    res.reg_write     = 1'b0;
    res.new_reg_value = 32'd0;
    st_nxt.pending    = 1'b0;
    st_nxt.addend     = 32'd0;
    if (req.action) begin
      if (st.pending) begin
        res.kind  = KIND_ADDR;
        res.value = req.mem_data + st.addend;
      end
    end else begin
      unique case (req.mode)
        MODE_DREG, MODE_AREG: begin
          res.kind  = KIND_DATA;
          res.value = req.base_reg_value;
        end
        MODE_IND: begin
          res.kind  = KIND_ADDR;
          res.value = req.base_reg_value;
        end
        MODE_POSTINC: begin
          if (req.size != SIZE_BAD) begin
            res.kind          = KIND_ADDR;
            res.value         = req.base_reg_value;
            res.reg_write     = 1'b1;
            res.new_reg_value = req.base_reg_value + step_ext;
          end
        end
        MODE_PREDEC: begin
          if (req.size != SIZE_BAD) begin
            res.kind          = KIND_ADDR;
            res.value         = req.base_reg_value - step_ext;
            res.reg_write     = 1'b1;
            res.new_reg_value = req.base_reg_value - step_ext;
          end
        end
        MODE_DISP16: begin
          res.kind  = KIND_ADDR;
          res.value = req.base_reg_value + sx_bd;
        end
        MODE_INDEX: begin
          res.kind       = idx_kind;
          res.value      = idx_val;
          st_nxt.pending = idx_pend;
          st_nxt.addend  = idx_addend;
        end
        default: begin
          unique case (req.reg_req)
            SUB_ABS_W: begin
              res.kind  = KIND_ADDR;
              res.value = sx_bd;
            end
            SUB_ABS_L: begin
              res.kind  = KIND_ADDR;
              res.value = req.base_disp;
            end
            SUB_PC_D16: begin
              res.kind  = KIND_ADDR;
              res.value = req.pc_value + sx_bd;
            end
            SUB_PC_INDEX: begin
              res.kind       = idx_kind;
              res.value      = idx_val;
              st_nxt.pending = idx_pend;
              st_nxt.addend  = idx_addend;
            end
            SUB_IMM: begin
              unique case (req.size)
                SIZE_BYTE: begin
                  res.kind  = KIND_DATA;
                  res.value = {24'd0, req.base_disp[7:0]};
                end
                SIZE_WORD: begin
                  res.kind  = KIND_DATA;
                  res.value = {16'd0, req.base_disp[15:0]};
                end
                SIZE_LONG: begin
                  res.kind  = KIND_DATA;
                  res.value = req.base_disp;
                end
                default: begin
                  res.kind = KIND_BAD;
                end
              endcase
            end
            default: begin
              res.kind = KIND_BAD;
            end
          endcase
        end
      endcase
    end
  end

endmodule
